>>> rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared widths, codes and state types for the roulette wheel selection block.
// ----------------------------------------------------------------------------
package rws_pkg;

   localparam int OP_W        = 2;
   localparam int ID_W        = 6;
   localparam int FIT_W       = 32;
   localparam int FRAC_W      = 32;
   localparam int WHEEL_W     = 49;
   localparam int MAG_W       = WHEEL_W - 1;
   localparam int POP_W       = 7;
   localparam int TRUNC_W     = 6;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = POP_W;

   localparam int DEFAULT_MAX_POPULATION = 64;

   localparam logic [POP_W-1:0] POP_RESET = 7'd64;

   localparam logic [CSR_INDEX_W-1:0] CSR_POPULATION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRUNCATED  = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_SELECT = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EARLY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD_CMP,
      S_LOAD_PUT,
      S_BASE,
      S_BUILD,
      S_REF,
      S_SCALE,
      S_SRCH,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_LO,
      SC_HI,
      SC_SUM
   } scale_state_type;

endpackage

>>> rtl/rws_if.sv
// ----------------------------------------------------------------------------
// rws_req_if / rws_rsp_if
// Valid/ready channels carrying selection requests and their responses.
// ----------------------------------------------------------------------------
interface rws_req_if import rws_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [ID_W-1:0]         individual_id;
   logic signed [FIT_W-1:0] fitness_value;
   logic [FRAC_W-1:0]       random_fraction;
   logic [ID_W-1:0]         random_individual;
   logic [ID_W-1:0]         excluded_individual;

   modport source (
      output valid, operation, individual_id, fitness_value,
             random_fraction, random_individual, excluded_individual,
      input  ready
   );
   modport sink (
      input  valid, operation, individual_id, fitness_value,
             random_fraction, random_individual, excluded_individual,
      output ready
   );
endinterface

interface rws_rsp_if import rws_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     selected_individual;
   logic                used_fallback;
   logic                matches_excluded;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, selected_individual, used_fallback, matches_excluded, status,
      input  ready
   );
   modport sink (
      input  valid, selected_individual, used_fallback, matches_excluded, status,
      output ready
   );
endinterface

>>> rtl/rws_scale.sv
// ----------------------------------------------------------------------------
// rws_scale
// Scales the wheel total by an unsigned 0.32 fraction, floor rounding, using
// one 32x32 multiplier over two passes (low and high half of the magnitude).
// ----------------------------------------------------------------------------
module rws_scale import rws_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [FRAC_W-1:0]         fraction,
   input  logic signed [WHEEL_W-1:0] total,
   output logic                      done,
   output logic signed [WHEEL_W-1:0] ref_value
);

   scale_state_type state_ff, state_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [2*FRAC_W-1:0]       prod_ff, prod_in;
   logic [FRAC_W-1:0]         plo_hi_ff, plo_hi_in;
   logic                      nz_ff, nz_in;
   logic signed [WHEEL_W-1:0] ref_ff, ref_in;
   logic                      done_ff, done_in;

   logic [FRAC_W-1:0]         mul_b;
   logic signed [WHEEL_W-1:0] total_abs;
   logic [WHEEL_W-1:0]        q;

   always_comb begin
      state_in  = state_ff;
      frac_in   = frac_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      plo_hi_in = plo_hi_ff;
      nz_in     = nz_ff;
      ref_in    = ref_ff;
      done_in   = 1'b0;

      total_abs = (total < 0) ? -total : total;
      mul_b     = (state_ff == SC_LO) ? mag_ff[FRAC_W-1:0]
                                      : FRAC_W'(mag_ff[MAG_W-1:FRAC_W]);
      q         = prod_ff[WHEEL_W-1:0] + WHEEL_W'(plo_hi_ff)
                  + WHEEL_W'(neg_ff && nz_ff);

      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               frac_in  = fraction;
               mag_in   = total_abs[MAG_W-1:0];
               neg_in   = total[WHEEL_W-1];
               state_in = SC_LO;
            end
         end
         SC_LO: begin
            prod_in  = (2*FRAC_W)'(frac_ff) * (2*FRAC_W)'(mul_b);
            state_in = SC_HI;
         end
         SC_HI: begin
            // keep the carry-in part of the low product, then reuse the multiplier
            plo_hi_in = prod_ff[2*FRAC_W-1:FRAC_W];
            nz_in     = |prod_ff[FRAC_W-1:0];
            prod_in   = (2*FRAC_W)'(frac_ff) * (2*FRAC_W)'(mul_b);
            state_in  = SC_SUM;
         end
         SC_SUM: begin
            ref_in   = neg_ff ? -$signed(q) : $signed(q);
            done_in  = 1'b1;
            state_in = SC_IDLE;
         end
         default: state_in = SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff   <= frac_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      plo_hi_ff <= plo_hi_in;
      nz_ff     <= nz_in;
      ref_ff    <= ref_in;
   end

   assign done      = done_ff;
   assign ref_value = ref_ff;

endmodule

>>> rtl/roulette_wheel_selection.sv
// ----------------------------------------------------------------------------
// roulette_wheel_selection
// Fitness-proportionate parent selection with truncation over a sorted table.
// ----------------------------------------------------------------------------
// One request is handled at a time; ready is high only between requests.
// A clear, an unused code, a load into a full table or an early select goes
// from decode straight to the response. A load into an empty table writes its
// entry at once; any other load first moves each stored entry of higher fitness
// up one slot, one per cycle, since insertion walks the sorted table through its
// single read port. A select on a built wheel waits for the shared multiplier
// (low and high passes and the registered result), then scans one wheel slot per
// cycle (up to population minus truncation). The first select after a load,
// clear or register write also rebuilds the wheel: one slot per cycle from the
// truncation point up to the population size, after a fetch of the baseline when
// entries are truncated. A response the receiver holds off keeps the block busy.
// ----------------------------------------------------------------------------
module roulette_wheel_selection import rws_pkg::*; #(
   parameter int MAX_POPULATION = DEFAULT_MAX_POPULATION
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   rws_req_if.sink                req_bus,
   rws_rsp_if.source              rsp_bus
);

   localparam int AW = $clog2(MAX_POPULATION);
   localparam int CW = $clog2(MAX_POPULATION + 1);

   // sorted table and cumulative wheel
   logic signed [FIT_W-1:0]   fit_mem_ff   [MAX_POPULATION];
   logic [ID_W-1:0]           id_mem_ff    [MAX_POPULATION];
   logic signed [WHEEL_W-1:0] wheel_mem_ff [MAX_POPULATION];
   logic signed [FIT_W-1:0]   fit_rd_ff;
   logic [ID_W-1:0]           id_rd_ff;
   logic signed [WHEEL_W-1:0] wheel_rd_ff;

   state_type state_ff, state_in;
   logic [POP_W-1:0]          pop_ff, pop_in;
   logic [TRUNC_W-1:0]        trunc_ff, trunc_in;
   logic [CW-1:0]             loaded_ff, loaded_in;
   logic                      wheel_ready_ff, wheel_ready_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic [ID_W-1:0]           id_ff, id_in;
   logic signed [FIT_W-1:0]   fit_ff, fit_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [ID_W-1:0]           rnd_ff, rnd_in;
   logic [ID_W-1:0]           excl_ff, excl_in;
   logic signed [FIT_W-1:0]   base_ff, base_in;
   logic signed [WHEEL_W-1:0] acc_ff, acc_in;
   logic signed [WHEEL_W-1:0] total_ff, total_in;
   logic [ID_W-1:0]           res_sel_ff, res_sel_in;
   logic                      res_fb_ff, res_fb_in;
   status_type                res_status_ff, res_status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]           rsp_sel_ff, rsp_sel_in;
   logic                      rsp_fb_ff, rsp_fb_in;
   logic                      rsp_match_ff, rsp_match_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic [CW-1:0]             n_eff;
   logic                      trunc_ge_n;
   logic                      idx_last;
   logic [AW-1:0]             rd_addr;
   logic                      tbl_we;
   logic [AW-1:0]             tbl_wr_addr;
   logic signed [FIT_W-1:0]   tbl_wr_fit;
   logic [ID_W-1:0]           tbl_wr_id;
   logic                      wheel_we;
   logic signed [WHEEL_W-1:0] acc_sum;
   logic                      scl_start;
   logic                      scl_done;
   logic signed [WHEEL_W-1:0] scl_ref;

   rws_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (scl_start),
      .fraction  (frac_ff),
      .total     (total_ff),
      .done      (scl_done),
      .ref_value (scl_ref)
   );

   // population size limited to 1..MAX_POPULATION
   always_comb begin
      if (pop_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(pop_ff) > MAX_POPULATION) begin
         n_eff = CW'(MAX_POPULATION);
      end else begin
         n_eff = CW'(pop_ff);
      end
   end

   assign trunc_ge_n = 32'(trunc_ff) >= 32'(n_eff);
   assign idx_last   = (32'(idx_ff) + 32'd1) == 32'(n_eff);
   assign acc_sum    = acc_ff + WHEEL_W'(fit_rd_ff) - WHEEL_W'(base_ff);

   always_comb begin
      state_in       = state_ff;
      pop_in         = pop_ff;
      trunc_in       = trunc_ff;
      loaded_in      = loaded_ff;
      wheel_ready_in = wheel_ready_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      fit_in         = fit_ff;
      frac_in        = frac_ff;
      rnd_in         = rnd_ff;
      excl_in        = excl_ff;
      base_in        = base_ff;
      acc_in         = acc_ff;
      total_in       = total_ff;
      res_sel_in     = res_sel_ff;
      res_fb_in      = res_fb_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_sel_in     = rsp_sel_ff;
      rsp_fb_in      = rsp_fb_ff;
      rsp_match_in   = rsp_match_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = idx_ff;
      tbl_we         = 1'b0;
      tbl_wr_addr    = idx_ff;
      tbl_wr_fit     = fit_ff;
      tbl_wr_id      = id_ff;
      wheel_we       = 1'b0;
      scl_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.operation;
               id_in    = req_bus.individual_id;
               fit_in   = req_bus.fitness_value;
               frac_in  = req_bus.random_fraction;
               rnd_in   = req_bus.random_individual;
               excl_in  = req_bus.excluded_individual;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_sel_in    = '0;
            res_fb_in     = 1'b0;
            res_status_in = ST_OK;
            state_in      = S_RESP;
            unique case (op_type'(op_ff))
               OP_CLEAR: begin
                  loaded_in      = '0;
                  wheel_ready_in = 1'b0;
               end
               OP_LOAD: begin
                  if (loaded_ff >= n_eff) begin
                     res_status_in = ST_FULL;
                  end else begin
                     idx_in = AW'(loaded_ff);
                     if (loaded_ff == '0) begin
                        state_in = S_LOAD_PUT;
                     end else begin
                        rd_addr  = AW'(loaded_ff - 1'b1);
                        state_in = S_LOAD_CMP;
                     end
                  end
               end
               OP_SELECT: begin
                  if (loaded_ff < n_eff) begin
                     res_status_in = ST_EARLY;
                  end else if (wheel_ready_ff) begin
                     state_in = S_REF;
                  end else if (trunc_ge_n) begin
                     // empty wheel: total is zero and every select falls back
                     total_in       = '0;
                     wheel_ready_in = 1'b1;
                     state_in       = S_REF;
                  end else if (trunc_ff != '0) begin
                     rd_addr  = AW'(trunc_ff - 1'b1);
                     state_in = S_BASE;
                  end else begin
                     base_in  = '0;
                     acc_in   = '0;
                     idx_in   = '0;
                     rd_addr  = '0;
                     state_in = S_BUILD;
                  end
               end
               default: ;
            endcase
         end
         S_LOAD_CMP: begin
            // shift the larger entry up one slot and keep walking down
            if (fit_rd_ff > fit_ff) begin
               tbl_we      = 1'b1;
               tbl_wr_addr = idx_ff;
               tbl_wr_fit  = fit_rd_ff;
               tbl_wr_id   = id_rd_ff;
               idx_in      = idx_ff - 1'b1;
               if (idx_ff == AW'(1)) begin
                  state_in = S_LOAD_PUT;
               end else begin
                  rd_addr = idx_ff - AW'(2);
               end
            end else begin
               state_in = S_LOAD_PUT;
            end
         end
         S_LOAD_PUT: begin
            tbl_we         = 1'b1;
            tbl_wr_addr    = idx_ff;
            loaded_in      = loaded_ff + 1'b1;
            wheel_ready_in = 1'b0;
            state_in       = S_RESP;
         end
         S_BASE: begin
            base_in  = fit_rd_ff;
            acc_in   = '0;
            idx_in   = AW'(trunc_ff);
            rd_addr  = AW'(trunc_ff);
            state_in = S_BUILD;
         end
         S_BUILD: begin
            wheel_we = 1'b1;
            acc_in   = acc_sum;
            if (idx_last) begin
               total_in       = acc_sum;
               wheel_ready_in = 1'b1;
               state_in       = S_REF;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         S_REF: begin
            scl_start = 1'b1;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            if (scl_done) begin
               if (trunc_ge_n) begin
                  res_sel_in = rnd_ff;
                  res_fb_in  = 1'b1;
                  state_in   = S_RESP;
               end else begin
                  idx_in   = AW'(trunc_ff);
                  rd_addr  = AW'(trunc_ff);
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (scl_ref < wheel_rd_ff) begin
               res_sel_in = id_rd_ff;
               state_in   = S_RESP;
            end else if (idx_last) begin
               res_sel_in = rnd_ff;
               res_fb_in  = 1'b1;
               state_in   = S_RESP;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sel_in    = res_sel_ff;
               rsp_fb_in     = res_fb_ff;
               rsp_status_in = res_status_ff;
               rsp_match_in  = (op_type'(op_ff) == OP_SELECT) && (res_status_ff == ST_OK)
                               && (res_sel_ff == excl_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POPULATION: begin
               pop_in         = csr_wdata;
               wheel_ready_in = 1'b0;
            end
            CSR_TRUNCATED: begin
               trunc_in       = csr_wdata[TRUNC_W-1:0];
               wheel_ready_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pop_ff         <= POP_RESET;
         trunc_ff       <= '0;
         loaded_ff      <= '0;
         wheel_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pop_ff         <= pop_in;
         trunc_ff       <= trunc_in;
         loaded_ff      <= loaded_in;
         wheel_ready_ff <= wheel_ready_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      fit_ff        <= fit_in;
      frac_ff       <= frac_in;
      rnd_ff        <= rnd_in;
      excl_ff       <= excl_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      total_ff      <= total_in;
      res_sel_ff    <= res_sel_in;
      res_fb_ff     <= res_fb_in;
      res_status_ff <= res_status_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_fb_ff     <= rsp_fb_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         fit_mem_ff[tbl_wr_addr] <= tbl_wr_fit;
         id_mem_ff[tbl_wr_addr]  <= tbl_wr_id;
      end
      fit_rd_ff <= fit_mem_ff[rd_addr];
      id_rd_ff  <= id_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wheel_we) begin
         wheel_mem_ff[idx_ff] <= acc_sum;
      end
      wheel_rd_ff <= wheel_mem_ff[rd_addr];
   end

   assign req_bus.ready               = (state_ff == S_IDLE);
   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.selected_individual = rsp_sel_ff;
   assign rsp_bus.used_fallback       = rsp_fb_ff;
   assign rsp_bus.matches_excluded    = rsp_match_ff;
   assign rsp_bus.status              = rsp_status_ff;

   a_scale_done_waited: assert property (@(posedge clock) disable iff (reset)
      scl_done |-> state_ff == S_SCALE)
      else $error("scale result arrived while not waiting for it");

   a_search_on_built_wheel: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> wheel_ready_ff)
      else $error("wheel searched before it was built");

   a_load_counts_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD_PUT |=> loaded_ff == $past(loaded_ff) + 1'b1)
      else $error("insertion did not advance the fill count by one");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(loaded_ff) <= MAX_POPULATION)
      else $error("fill count exceeds table depth");

endmodule
